// ===== design/nfa_pkg.sv =====
`default_nettype none

package nfa_pkg;

  // FU-A payload type carried in the FU indicator
  localparam logic [4:0]  FuaType      = 5'd28;
  // max_packet_size after reset
  localparam logic [15:0] MaxPktReset  = 16'd1400;
  // smallest usable packet size, leaving one payload byte per fragment
  localparam logic [15:0] MaxPktFloor  = 16'd3;
  // bytes of FU indicator plus FU header
  localparam logic [15:0] FuHdrBytes   = 16'd2;
  // result slots per request
  localparam int unsigned NumSlots     = 3;

  // Results of one input request, emitted from slot 0 upwards
  typedef struct packed {
    logic [1:0]                cnt;
    logic [NumSlots-1:0][7:0]  data;
    logic [NumSlots-1:0]       first;
    logic [NumSlots-1:0]       last;
  } res_t;

endpackage

`default_nettype wire

// ===== design/nfa_frag_logic.sv =====
`default_nettype none

module nfa_frag_logic
  import nfa_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic [15:0] max_pkt_i,
  input  wire logic [7:0]  data_byte_i,
  input  wire logic        nal_start_i,
  input  wire logic [15:0] nal_length_i,
  input  wire logic        fire_i,
  output res_t             res_o
);

  logic [15:0] off_q,  off_d;
  logic [15:0] fill_q, fill_d;
  logic [15:0] ulen_q, ulen_d;
  logic [1:0]  pri_q,  pri_d;
  logic [4:0]  typ_q,  typ_d;

  // Fragment cutting and FU byte generation for the staged request
  always_comb begin
    logic [15:0] p;
    logic [15:0] len_eff;
    logic [7:0]  ind;
    logic        end_bit;
    logic        s_bit;
    logic        hdr_last;
    logic        dat_last;
    logic [16:0] fill_inc;

    p        = (max_pkt_i < MaxPktFloor) ? 16'd1 : (max_pkt_i - FuHdrBytes);
    len_eff  = (nal_length_i == 16'd0) ? 16'd1 : nal_length_i;
    fill_inc = {1'b0, fill_q} + 17'd1;
    ind      = '0;
    end_bit  = 1'b0;
    s_bit    = 1'b0;
    hdr_last = 1'b0;
    dat_last = 1'b0;

    res_o  = '0;
    off_d  = off_q;
    fill_d = fill_q;
    ulen_d = ulen_q;
    pri_d  = pri_q;
    typ_d  = typ_q;

    if (nal_start_i) begin
      // header byte: only its NRI and type survive
      ind      = {1'b0, data_byte_i[6:5], FuaType};
      end_bit  = (len_eff <= p);
      s_bit    = (len_eff > p);
      hdr_last = (len_eff == 16'd1) || (p == 16'd1);
      res_o.cnt      = 2'd2;
      res_o.data[0]  = ind;
      res_o.first[0] = 1'b1;
      res_o.data[1]  = {s_bit, end_bit, 1'b0, data_byte_i[4:0]};
      res_o.last[1]  = hdr_last;
      off_d  = 16'd1;
      fill_d = (p == 16'd1) ? 16'd0 : 16'd1;
      ulen_d = len_eff;
      pri_d  = data_byte_i[6:5];
      typ_d  = data_byte_i[4:0];
    end else if (off_q < ulen_q) begin
      ind      = {1'b0, pri_q, FuaType};
      end_bit  = ((ulen_q - off_q) <= p);
      dat_last = (({1'b0, off_q} + 17'd1) == {1'b0, ulen_q}) || (fill_inc >= {1'b0, p});
      if (fill_q == 16'd0) begin
        // fragment boundary: indicator, FU header, then the byte
        res_o.cnt      = 2'd3;
        res_o.data[0]  = ind;
        res_o.first[0] = 1'b1;
        res_o.data[1]  = {1'b0, end_bit, 1'b0, typ_q};
        res_o.data[2]  = data_byte_i;
        res_o.last[2]  = dat_last;
      end else begin
        res_o.cnt     = 2'd1;
        res_o.data[0] = data_byte_i;
        res_o.last[0] = dat_last;
      end
      off_d  = off_q + 16'd1;
      fill_d = (fill_inc >= {1'b0, p}) ? 16'd0 : fill_inc[15:0];
    end
  end

  // Unit tracking state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      off_q  <= '0;
      fill_q <= '0;
      ulen_q <= '0;
      pri_q  <= '0;
      typ_q  <= '0;
    end else if (fire_i) begin
      off_q  <= off_d;
      fill_q <= fill_d;
      ulen_q <= ulen_d;
      pri_q  <= pri_d;
      typ_q  <= typ_d;
    end
  end

  // Offset never runs past the unit length
  a_off_in_unit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    off_q <= ulen_q)
    else $error("byte offset beyond unit length");

  // Indicator opens every multi-byte result group, and only those
  a_first_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.cnt != 2'd0) |-> (res_o.first[0] == (res_o.cnt != 2'd1)))
    else $error("indicator placement wrong");

  // A start request always yields exactly indicator and FU header
  a_start_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    nal_start_i |-> (res_o.cnt == 2'd2))
    else $error("start request result count wrong");

endmodule

`default_nettype wire

// ===== design/nfa_out_buf.sv =====
`default_nettype none

module nfa_out_buf
  import nfa_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire res_t       res_i,
  input  wire logic       load_i,
  output logic            can_load_o,
  output logic            m_axis_tvalid,
  input  wire logic       m_axis_tready,
  output logic [7:0]      m_axis_tdata,  // [7:0] out_byte
  output logic [1:0]      m_axis_tuser,  // [0] packet_first, [1] run_last
  output logic            m_axis_tlast   // packet_last
);

  logic [1:0]               cnt_q, cnt_d;
  logic [NumSlots-1:0][7:0] data_q, data_d;
  logic [NumSlots-1:0]      first_q, first_d;
  logic [NumSlots-1:0]      last_q, last_d;
  logic                     take;

  assign take       = m_axis_tvalid && m_axis_tready;
  assign can_load_o = (cnt_q == 2'd0) || ((cnt_q == 2'd1) && m_axis_tready);

  // Load a fresh group or shift the emitted slot out
  always_comb begin
    cnt_d   = cnt_q;
    data_d  = data_q;
    first_d = first_q;
    last_d  = last_q;
    if (load_i) begin
      cnt_d   = res_i.cnt;
      data_d  = res_i.data;
      first_d = res_i.first;
      last_d  = res_i.last;
    end else if (take) begin
      cnt_d   = cnt_q - 2'd1;
      data_d  = {8'd0, data_q[NumSlots-1:1]};
      first_d = {1'b0, first_q[NumSlots-1:1]};
      last_d  = {1'b0, last_q[NumSlots-1:1]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q  <= data_d;
    first_q <= first_d;
    last_q  <= last_d;
  end

  assign m_axis_tvalid   = (cnt_q != 2'd0);
  assign m_axis_tdata    = data_q[0];
  assign m_axis_tuser[0] = first_q[0];
  assign m_axis_tuser[1] = (cnt_q == 2'd1);
  assign m_axis_tlast    = last_q[0];

  // An indicator byte is always followed by its FU header
  a_ind_then_hdr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser[0]) |-> (cnt_q >= 2'd2))
    else $error("indicator without FU header");

  // Indicator never closes a fragment
  a_ind_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(m_axis_tuser[0] && m_axis_tlast))
    else $error("indicator flagged as fragment end");

  // No new group lands on top of undelivered results
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load_i && (cnt_q != 2'd0)) |-> take)
    else $error("result group overwritten");

endmodule

`default_nettype wire

// ===== design/nal_fu_a_fragmenter.sv =====
`default_nettype none

// H.264 FU-A fragmenter. Each NAL unit arrives one byte per request, header
// byte first with nal_start set and the unit length alongside. The header
// byte yields the FU indicator and FU header of the first fragment; every
// max_packet_size-2 unit bytes (1 if below 3) a new indicator/header pair is
// inserted ahead of the data byte. Requests pass through an input register,
// combinational fragment logic and a three-slot result register that drains
// one byte per cycle while m_axis_tready is high. A data byte in a fragment
// yields one output byte, a header byte two, a boundary byte three. Bytes out
// of a unit are swallowed without stalling. Users must write max_packet_size
// on the cfg channel only while the stream is idle; the block does not check.
module nal_fu_a_fragmenter
  import nfa_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [15:0] cfg_data_i,     // max_packet_size
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [23:0] s_axis_tdata,   // [7:0] data_byte, [23:8] nal_length
  input  wire logic        s_axis_tuser,   // nal_start
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [7:0]       m_axis_tdata,   // [7:0] out_byte
  output logic [1:0]       m_axis_tuser,   // [0] packet_first, [1] run_last
  output logic             m_axis_tlast    // packet_last
);

  logic [15:0] max_pkt_q;
  logic        stg_vld_q;
  logic [7:0]  stg_byte_q;
  logic        stg_start_q;
  logic [15:0] stg_len_q;
  logic        stg_fire;
  logic        can_load;
  logic        s_take;
  res_t        res;

  // Configuration register
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_pkt_q <= MaxPktReset;
    end else if (cfg_valid_i) begin
      max_pkt_q <= cfg_data_i;
    end
  end

  // Input register
  assign stg_fire      = stg_vld_q && (can_load || (res.cnt == 2'd0));
  assign s_axis_tready = !stg_vld_q || stg_fire;
  assign s_take        = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stg_vld_q <= 1'b0;
    end else if (s_axis_tready) begin
      stg_vld_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_take) begin
      stg_byte_q  <= s_axis_tdata[7:0];
      stg_len_q   <= s_axis_tdata[23:8];
      stg_start_q <= s_axis_tuser;
    end
  end

  nfa_frag_logic u_frag (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .max_pkt_i    (max_pkt_q),
    .data_byte_i  (stg_byte_q),
    .nal_start_i  (stg_start_q),
    .nal_length_i (stg_len_q),
    .fire_i       (stg_fire),
    .res_o        (res)
  );

  nfa_out_buf u_out (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .res_i         (res),
    .load_i        (stg_fire && (res.cnt != 2'd0)),
    .can_load_o    (can_load),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

`default_nettype wire

// ===== sim/tb.sv =====
`default_nettype none

module tb;
  import nfa_pkg::*;

  localparam int DrainCycles = 16;   // covers input reg, fragment stage and result slots
  localparam int HoldCycles  = 200;
  localparam int RandomBusy  = 420;
  localparam int MaxReports  = 10;

  // one output byte with its flags
  typedef struct packed {
    logic [7:0] octet;
    logic       pkt_first;
    logic       pkt_last;
    logic       run_last;
  } frag_res_t;

  typedef enum logic {ROW_BYTE, ROW_CFG} row_kind_e;

  // directed row; for ROW_CFG the len field carries the max_packet_size value
  typedef struct {
    row_kind_e   kind;
    logic [7:0]  data;
    logic        start;
    logic [15:0] len;
    int          n_typed;   // -1: expectation comes from the fragment model
    frag_res_t   typed [3];
  } stim_row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [15:0] cfg_data_i;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata;   // [7:0] data_byte, [23:8] nal_length
  logic        s_axis_tuser;   // nal_start
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [7:0]  m_axis_tdata;   // [7:0] out_byte
  logic [1:0]  m_axis_tuser;   // [0] packet_first, [1] run_last
  logic        m_axis_tlast;   // packet_last

  nal_fu_a_fragmenter dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  // fragmenter model state
  logic [15:0] pkt_size;
  logic [15:0] unit_off;
  logic [15:0] frag_fill;
  logic [15:0] unit_len;
  logic [1:0]  unit_nri;
  logic [4:0]  unit_kind;

  frag_res_t   frag_q [$];
  frag_res_t   no_typed [3];
  int          mism_cnt = 0;
  int          src_idle = 0;
  int          snk_idle = 0;
  bit          hold_req = 1'b0;

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // watchdog
  initial begin
    #5_000_000;
    $display("tb: failure");
    $finish;
  end

  // Fragment model: bytes produced by one accepted request
  function automatic int fragment_byte(input logic [7:0] d, input logic s,
                                       input logic [15:0] l, output frag_res_t res [3]);
    logic [15:0] payload;
    logic [15:0] ulen;
    logic        s_bit;
    logic        hdr_last;
    logic        last;
    int          n;
    payload = ((pkt_size < MaxPktFloor) ? MaxPktFloor : pkt_size) - FuHdrBytes;
    n = 0;
    res = '{default: '0};
    if (s) begin
      ulen      = (l == 16'd0) ? 16'd1 : l;
      unit_len  = ulen;
      unit_nri  = d[6:5];
      unit_kind = d[4:0];
      unit_off  = 16'd0;
      frag_fill = 16'd0;
      s_bit     = ulen > payload;
      hdr_last  = (ulen == 16'd1) || (payload == 16'd1);
      res[0] = frag_res_t'{{1'b0, unit_nri, FuaType}, 1'b1, 1'b0, 1'b0};
      res[1] = frag_res_t'{{s_bit, (unit_len - unit_off) <= payload, 1'b0, unit_kind},
                           1'b0, hdr_last, 1'b0};
      n = 2;
    end else begin
      // no open unit: byte is dropped
      if (unit_off >= unit_len) return 0;
      if (frag_fill == 16'd0) begin
        res[0] = frag_res_t'{{1'b0, unit_nri, FuaType}, 1'b1, 1'b0, 1'b0};
        res[1] = frag_res_t'{{1'b0, (unit_len - unit_off) <= payload, 1'b0, unit_kind},
                             1'b0, 1'b0, 1'b0};
        n = 2;
      end
      last = (unit_off + 16'd1 == unit_len) || (frag_fill + 16'd1 >= payload);
      res[n] = frag_res_t'{d, 1'b0, last, 1'b0};
      n++;
    end
    unit_off  = unit_off + 16'd1;
    frag_fill = frag_fill + 16'd1;
    if (frag_fill >= payload) frag_fill = 16'd0;
    res[n-1].run_last = 1'b1;
    return n;
  endfunction

  // offer one request, with random idling ahead of it
  task automatic send_item(input logic [7:0] d, input logic s, input logic [15:0] l,
                           input int n_typed, input frag_res_t typed [3], output int n);
    frag_res_t res [3];
    while ($urandom_range(99) < src_idle) begin
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {l, d};
    s_axis_tuser  <= s;
    do @(posedge clk_i); while (!s_axis_tready);
    n = fragment_byte(d, s, l, res);
    if (n_typed >= 0) begin
      n = n_typed;
      for (int i = 0; i < n; i++) frag_q.push_back(typed[i]);
    end else begin
      for (int i = 0; i < n; i++) frag_q.push_back(res[i]);
    end
  endtask

  // stop sending and let every pending byte drain out
  task automatic wait_idle();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (frag_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_cfg(input logic [15:0] v);
    wait_idle();
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    pkt_size = v;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic stim_row_t byte_row(input logic [7:0] d, input logic s,
                                         input logic [15:0] l);
    stim_row_t r;
    r.kind    = ROW_BYTE;
    r.data    = d;
    r.start   = s;
    r.len     = l;
    r.n_typed = -1;
    r.typed   = '{default: '0};
    return r;
  endfunction

  function automatic stim_row_t cfg_row(input logic [15:0] v);
    stim_row_t r;
    r = byte_row(8'h00, 1'b0, v);
    r.kind = ROW_CFG;
    return r;
  endfunction

  function automatic stim_row_t typed_row(input logic [7:0] d, input logic s,
                                          input logic [15:0] l, input int n,
                                          input frag_res_t a, input frag_res_t b);
    stim_row_t r;
    r = byte_row(d, s, l);
    r.n_typed  = n;
    r.typed[0] = a;
    r.typed[1] = b;
    return r;
  endfunction

  // receiver: random back-pressure, plus a long hold-off on request
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        m_axis_tready <= 1'b0;
        repeat (HoldCycles - 1) @(negedge clk_i);
        hold_req = 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= snk_idle);
      end
    end
  end

  // output check against the oldest pending byte
  always @(posedge clk_i) begin
    frag_res_t got;
    frag_res_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = frag_res_t'{m_axis_tdata, m_axis_tuser[0], m_axis_tlast, m_axis_tuser[1]};
      if (frag_q.size() == 0) begin
        mism_cnt++;
        if (mism_cnt <= MaxReports)
          $display("tb: unexpected byte %02h first=%0b last=%0b run_last=%0b",
                   got.octet, got.pkt_first, got.pkt_last, got.run_last);
      end else begin
        want = frag_q.pop_front();
        if (got.octet !== want.octet || got.pkt_first !== want.pkt_first ||
            got.pkt_last !== want.pkt_last || got.run_last !== want.run_last) begin
          mism_cnt++;
          if (mism_cnt <= MaxReports)
            $display("tb: mismatch exp %02h/%0b/%0b/%0b got %02h/%0b/%0b/%0b",
                     want.octet, want.pkt_first, want.pkt_last, want.run_last,
                     got.octet, got.pkt_first, got.pkt_last, got.run_last);
        end
      end
    end
  end

  // stimulus
  initial begin
    stim_row_t   rows [$];
    int          n;
    int          busy;
    int          phase;
    int          r;
    int          nsend;
    logic [15:0] len;
    logic [15:0] cval;

    rst_ni        = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_data_i    = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = 1'b0;
    no_typed      = '{default: '0};
    pkt_size      = MaxPktReset;
    unit_off      = '0;
    frag_fill     = '0;
    unit_len      = '0;
    unit_nri      = '0;
    unit_kind     = '0;
    src_idle      = 23;
    snk_idle      = 85;

    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed part, reset packet size first
    rows.push_back(typed_row(8'hA5, 1'b0, 16'd0, 0, '0, '0));       // nothing open yet
    rows.push_back(typed_row(8'hFF, 1'b1, 16'd1, 2,                  // single-byte unit
                             frag_res_t'{8'h7C, 1'b1, 1'b0, 1'b0},
                             frag_res_t'{8'h5F, 1'b0, 1'b1, 1'b1}));
    rows.push_back(typed_row(8'h5A, 1'b0, 16'hFFFF, 0, '0, '0));     // unit already done
    rows.push_back(typed_row(8'h00, 1'b1, 16'd0, 2,                  // zero length -> 1
                             frag_res_t'{8'h1C, 1'b1, 1'b0, 1'b0},
                             frag_res_t'{8'h40, 1'b0, 1'b1, 1'b1}));
    rows.push_back(byte_row(8'h65, 1'b1, 16'd3));
    rows.push_back(byte_row(8'hFF, 1'b0, 16'h0000));
    rows.push_back(byte_row(8'h00, 1'b0, 16'hFFFF));
    rows.push_back(byte_row(8'h7F, 1'b1, 16'hFFFF));                 // longest unit
    rows.push_back(byte_row(8'h12, 1'b0, 16'h0000));
    rows.push_back(byte_row(8'h41, 1'b1, 16'd2));                    // restart mid-unit
    rows.push_back(byte_row(8'h33, 1'b0, 16'h0000));
    // register below the floor: one payload byte per fragment
    rows.push_back(cfg_row(16'd0));
    rows.push_back(typed_row(8'hE3, 1'b1, 16'd3, 2,
                             frag_res_t'{8'h7C, 1'b1, 1'b0, 1'b0},
                             frag_res_t'{8'h83, 1'b0, 1'b1, 1'b1}));
    rows.push_back(byte_row(8'h11, 1'b0, 16'h0000));
    rows.push_back(byte_row(8'h22, 1'b0, 16'h0000));
    // packet size 8: six payload bytes, boundary inside the unit
    rows.push_back(cfg_row(16'd8));
    rows.push_back(byte_row(8'h28, 1'b1, 16'd9));
    for (int i = 0; i < 6; i++) rows.push_back(byte_row(8'(8'h80 + i), 1'b0, 16'h0000));
    rows.push_back(cfg_row(16'hFFFF));
    rows.push_back(byte_row(8'h3C, 1'b1, 16'd4));
    for (int i = 0; i < 3; i++) rows.push_back(byte_row(8'(8'hF0 + i), 1'b0, 16'h0000));

    foreach (rows[i]) begin
      if (rows[i].kind == ROW_CFG) write_cfg(rows[i].len);
      else send_item(rows[i].data, rows[i].start, rows[i].len,
                     rows[i].n_typed, rows[i].typed, n);
    end

    // random part: phases of well-formed units with some broken ones and noise
    busy  = 0;
    phase = 0;
    while (busy < RandomBusy) begin
      if (busy < RandomBusy / 3) begin
        src_idle = 23;
        snk_idle = 85;
      end else if (busy < 2 * RandomBusy / 3) begin
        src_idle = 85;
        snk_idle = 23;
      end else begin
        src_idle = 0;
        snk_idle = 0;
      end
      case ($urandom_range(7))
        0:       cval = 16'($urandom_range(7));
        1, 2, 3: cval = 16'($urandom_range(24, 8));
        4:       cval = 16'($urandom_range(300, 25));
        5:       cval = MaxPktReset;
        6:       cval = 16'hFFFF;
        default: cval = 16'($urandom_range(16'hFFFF));
      endcase
      write_cfg(cval);
      if (phase % 3 == 1) hold_req = 1'b1;
      repeat ($urandom_range(8, 3)) begin
        r = int'($urandom_range(99));
        if (r < 8)       len = 16'($urandom_range(16'hFFFF));
        else if (r < 12) len = 16'd0;
        else             len = 16'($urandom_range(40, 1));
        send_item(8'($urandom_range(255)), 1'b1, len, -1, no_typed, n);
        busy++;
        nsend = (len <= 16'd1) ? 0 : ((len > 16'd41) ? 40 : int'(len) - 1);
        // truncated unit: the next header restarts early
        if (r >= 12 && r < 22) nsend = int'($urandom_range(nsend));
        repeat (nsend) begin
          send_item(8'($urandom_range(255)), 1'b0, 16'($urandom_range(16'hFFFF)),
                    -1, no_typed, n);
          if (n > 0) busy++;
        end
        // extra bytes, outside the unit unless it was cut short
        if ($urandom_range(99) < 12)
          repeat ($urandom_range(3, 1))
            send_item(8'($urandom_range(255)), 1'b0, 16'($urandom_range(16'hFFFF)),
                      -1, no_typed, n);
        if ($urandom_range(99) < 5) wait_idle();
      end
      phase++;
    end

    wait_idle();
    if (mism_cnt == 0 && frag_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== sim.f =====
design/nfa_pkg.sv
design/nfa_frag_logic.sv
design/nfa_out_buf.sv
design/nal_fu_a_fragmenter.sv
sim/tb.sv
